[src/rpc_transaction_id_remap_table_core_assert.svh]
// Assertion macros for the transaction id remap table.
// Included by rtirt_dpath, which checks its own logic; needs no package.
`ifndef RPC_TRANSACTION_ID_REMAP_TABLE_CORE_ASSERT_SVH
`define RPC_TRANSACTION_ID_REMAP_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RTIRT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define RTIRT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/rtirt_pkg.sv]
// Shared types, codes and constants of the transaction id remap table.
// No dependencies.
package rtirt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int TYPE_BITS     = 4;
   localparam int TAG_BITS      = 16;
   localparam int ID_CTR_BITS   = 28;

   localparam logic [15:0] TAG_MASK = (TAG_BITS >= 16) ? 16'hFFFF :
                                      16'((32'd1 << TAG_BITS) - 32'd1);
   localparam logic [7:0]  LIFETIME_RESET = 8'd43;

   localparam logic [7:0] CSR_LIFETIME = 8'd0;
   localparam logic [7:0] CSR_SHUTDOWN = 8'd1;

   typedef enum logic [2:0] {
      KIND_SENT      = 3'd0,
      KIND_REJECTED  = 3'd1,
      KIND_FULL      = 3'd2,
      KIND_NOTICE    = 3'd3,
      KIND_MATCHED   = 3'd4,
      KIND_UNMATCHED = 3'd5
   } result_kind_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] type_id;
      logic [31:0] original_id;
      logic [31:0] reply_id;
      logic [15:0] client_tag;
      logic [31:0] now_seconds;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] id_value;
      logic [15:0] result_tag;
      logic        last_result;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] new_id;
      logic [31:0] old_id;
      logic [31:0] expiry;
      logic [15:0] tag;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN_ID,
      ST_SCAN_EXP,
      ST_EMIT_SENT
   } state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_FINAL,
      EMIT_NOTICE,
      EMIT_SENT
   } emit_type;

   typedef enum logic {
      SCAN_BY_ID,
      SCAN_EXPIRED
   } scan_mode_type;

   typedef struct packed {
      logic          load;
      logic          form_id;
      logic          scan_go;
      scan_mode_type scan_mode;
      logic          drop;
      logic          commit;
      emit_type      emit;
   } cmd_type;

   typedef struct packed {
      logic shut;
      logic is_reply;
      logic qualified;
      logic scan_done;
      logic best_found;
      logic free_found;
   } status_type;

endpackage

[src/rpc_transaction_id_remap_table_core.sv]
// Transaction id remap table, top level. N = TABLE_ENTRIES.
// On shutdown the final item is emitted from the decide state without a scan; a
// reply or unqualified request scans the table once, a qualified request by id
// and then for expiry, and an expiry notice may go before the final item. One item
// at a time: a new item is accepted only while idle. Results cannot be stalled.
// Synchronous reset clears valid bits and counters at once.
module rpc_transaction_id_remap_table_core #(
   parameter int TABLE_ENTRIES = rtirt_pkg::TABLE_ENTRIES,
   parameter int TYPE_BITS     = rtirt_pkg::TYPE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  rtirt_pkg::req_item_type req_data,
   output logic                    rsp_strobe,
   output rtirt_pkg::rsp_item_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_index,
   input  logic [7:0]              csr_wdata
);

   rtirt_pkg::cmd_type    cmd;
   rtirt_pkg::status_type status;

   rtirt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rtirt_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .TYPE_BITS     (TYPE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

[src/rtirt_ctrl.sv]
// Controller of the transaction id remap table: sequences decide, scans,
// writeback and result emission. Depends on rtirt_pkg.
module rtirt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rtirt_pkg::status_type status,
   output rtirt_pkg::cmd_type    cmd
);

   rtirt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtirt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtirt_pkg::ST_IDLE: begin
            if (start) state_in = rtirt_pkg::ST_DECIDE;
         end
         rtirt_pkg::ST_DECIDE: begin
            if (status.shut) state_in = rtirt_pkg::ST_IDLE;
            else if (status.is_reply || status.qualified) state_in = rtirt_pkg::ST_SCAN_ID;
            else state_in = rtirt_pkg::ST_SCAN_EXP;
         end
         rtirt_pkg::ST_SCAN_ID: begin
            if (status.scan_done) begin
               if (status.is_reply) state_in = rtirt_pkg::ST_IDLE;
               else state_in = rtirt_pkg::ST_SCAN_EXP;
            end
         end
         rtirt_pkg::ST_SCAN_EXP: begin
            if (status.scan_done) begin
               if (status.best_found) state_in = rtirt_pkg::ST_EMIT_SENT;
               else state_in = rtirt_pkg::ST_IDLE;
            end
         end
         rtirt_pkg::ST_EMIT_SENT: begin
            state_in = rtirt_pkg::ST_IDLE;
         end
         default: begin
            state_in = rtirt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.scan_mode = rtirt_pkg::SCAN_BY_ID;
      cmd.emit      = rtirt_pkg::EMIT_NONE;
      busy          = 1'b1;
      case (state_ff)
         rtirt_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         rtirt_pkg::ST_DECIDE: begin
            if (status.shut) begin
               cmd.emit = rtirt_pkg::EMIT_FINAL;
            end else if (status.is_reply) begin
               cmd.scan_go = 1'b1;
            end else begin
               cmd.form_id = 1'b1;
               cmd.scan_go = 1'b1;
               if (!status.qualified) cmd.scan_mode = rtirt_pkg::SCAN_EXPIRED;
            end
         end
         rtirt_pkg::ST_SCAN_ID: begin
            if (status.scan_done) begin
               cmd.drop = 1'b1;
               if (status.is_reply) begin
                  cmd.emit = rtirt_pkg::EMIT_FINAL;
               end else begin
                  cmd.scan_go   = 1'b1;
                  cmd.scan_mode = rtirt_pkg::SCAN_EXPIRED;
               end
            end
         end
         rtirt_pkg::ST_SCAN_EXP: begin
            if (status.scan_done) begin
               if (status.best_found) begin
                  cmd.commit = 1'b1;
                  cmd.emit   = rtirt_pkg::EMIT_NOTICE;
               end else begin
                  cmd.commit = status.free_found;
                  cmd.emit   = rtirt_pkg::EMIT_FINAL;
               end
            end
         end
         rtirt_pkg::ST_EMIT_SENT: begin
            cmd.emit = rtirt_pkg::EMIT_SENT;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[src/rtirt_dpath.sv]
// Datapath of the transaction id remap table: slot memory, valid bits,
// recency scan, id counters, configuration and result register.
// Depends on rtirt_pkg and the assertion macro header.
`include "rpc_transaction_id_remap_table_core_assert.svh"

module rtirt_dpath #(
   parameter int TABLE_ENTRIES = rtirt_pkg::TABLE_ENTRIES,
   parameter int TYPE_BITS     = rtirt_pkg::TYPE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rtirt_pkg::cmd_type      cmd,
   output rtirt_pkg::status_type   status,
   input  rtirt_pkg::req_item_type req_data,
   output logic                    rsp_strobe,
   output rtirt_pkg::rsp_item_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_index,
   input  logic [7:0]              csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   rtirt_pkg::req_item_type item_ff, load_item;
   logic [7:0]  lifetime_ff;
   logic        shut_ff;
   logic [rtirt_pkg::ID_CTR_BITS-1:0] id_ctr_ff;
   logic [31:0] ins_ctr_ff;
   logic [31:0] new_id_ff;
   logic [TABLE_ENTRIES-1:0] vld_ff;
   rtirt_pkg::entry_type mem [TABLE_ENTRIES];

   logic [IDX_W-1:0] idx_ff, rd_idx_ff, best_idx_ff, free_idx_ff, slot;
   logic issue_ff, rd_vld_ff, done_ff;
   rtirt_pkg::scan_mode_type mode_ff;
   rtirt_pkg::entry_type rd_entry_ff, wr_entry;
   logic        best_found_ff, free_found_ff;
   logic [31:0] best_age_ff, best_new_ff, best_old_ff;
   logic [15:0] best_tag_ff;

   logic        rsp_strobe_ff;
   rtirt_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [31:0] key, age;
   logic        hit, take, free_take;
   logic [32:0] exp_sum;

   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign status.shut       = shut_ff;
   assign status.is_reply   = item_ff.req_type;
   assign status.qualified  = |(item_ff.type_id >> TYPE_BITS);
   assign status.scan_done  = done_ff;
   assign status.best_found = best_found_ff;
   assign status.free_found = free_found_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= rtirt_pkg::LIFETIME_RESET;
         shut_ff     <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == rtirt_pkg::CSR_LIFETIME) lifetime_ff <= csr_wdata;
         else if (csr_index == rtirt_pkg::CSR_SHUTDOWN) shut_ff <= csr_wdata[0];
      end
   end

   always_comb begin
      load_item            = req_data;
      load_item.client_tag = req_data.client_tag & rtirt_pkg::TAG_MASK;
   end

   // latch item, form the new id
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= load_item;
      end
      if (cmd.form_id) begin
         if (status.qualified) new_id_ff <= item_ff.type_id;
         else new_id_ff <= (32'(id_ctr_ff) << TYPE_BITS) | item_ff.type_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ctr_ff  <= '0;
         ins_ctr_ff <= '0;
      end else begin
         if (cmd.form_id && !status.qualified) id_ctr_ff <= id_ctr_ff + 1'b1;
         if (cmd.commit) ins_ctr_ff <= ins_ctr_ff + 32'd1;
      end
   end

   // scan address sequencer, one entry read per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= issue_ff;
         done_ff   <= rd_vld_ff && (rd_idx_ff == LAST_IDX);
         if (cmd.scan_go) issue_ff <= 1'b1;
         else if (idx_ff == LAST_IDX) issue_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (cmd.scan_go) begin
         idx_ff  <= '0;
         mode_ff <= cmd.scan_mode;
      end else if (issue_ff) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // slot memory
   assign exp_sum = {1'b0, item_ff.now_seconds} + {25'd0, lifetime_ff};
   assign slot    = best_found_ff ? best_idx_ff : free_idx_ff;

   always_comb begin
      wr_entry.new_id = new_id_ff;
      wr_entry.old_id = item_ff.original_id;
      wr_entry.expiry = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
      wr_entry.tag    = item_ff.client_tag;
      wr_entry.stamp  = ins_ctr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) mem[slot] <= wr_entry;
      rd_entry_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.commit) begin
         vld_ff[slot] <= 1'b1;
      end else if (cmd.drop && best_found_ff) begin
         vld_ff[best_idx_ff] <= 1'b0;
      end
   end

   // recency compare on the entry just read
   assign key = item_ff.req_type ? item_ff.reply_id : item_ff.type_id;
   assign age = ins_ctr_ff - rd_entry_ff.stamp;

   always_comb begin
      if (mode_ff == rtirt_pkg::SCAN_BY_ID) hit = (rd_entry_ff.new_id == key);
      else hit = (rd_entry_ff.expiry <= item_ff.now_seconds);
      take      = rd_vld_ff && vld_ff[rd_idx_ff] && hit &&
                  (!best_found_ff || (age < best_age_ff));
      free_take = rd_vld_ff && (mode_ff == rtirt_pkg::SCAN_EXPIRED) &&
                  !vld_ff[rd_idx_ff] && !free_found_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_go) begin
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (take) best_found_ff <= 1'b1;
         if (free_take) free_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff <= rd_idx_ff;
         best_age_ff <= age;
         best_new_ff <= rd_entry_ff.new_id;
         best_old_ff <= rd_entry_ff.old_id;
         best_tag_ff <= rd_entry_ff.tag;
      end
      if (free_take) free_idx_ff <= rd_idx_ff;
   end

   // result register
   always_comb begin
      rsp_in = '0;
      case (cmd.emit)
         rtirt_pkg::EMIT_FINAL: begin
            rsp_in.last_result = 1'b1;
            if (shut_ff) begin
               if (item_ff.req_type) begin
                  rsp_in.result_kind = rtirt_pkg::KIND_UNMATCHED;
                  rsp_in.id_value    = item_ff.reply_id;
               end else begin
                  rsp_in.result_kind = rtirt_pkg::KIND_REJECTED;
                  rsp_in.result_tag  = item_ff.client_tag;
               end
            end else if (item_ff.req_type) begin
               if (best_found_ff) begin
                  rsp_in.result_kind = rtirt_pkg::KIND_MATCHED;
                  rsp_in.id_value    = best_old_ff;
                  rsp_in.result_tag  = best_tag_ff;
               end else begin
                  rsp_in.result_kind = rtirt_pkg::KIND_UNMATCHED;
                  rsp_in.id_value    = item_ff.reply_id;
               end
            end else begin
               rsp_in.result_kind = free_found_ff ? rtirt_pkg::KIND_SENT
                                                  : rtirt_pkg::KIND_FULL;
               rsp_in.id_value    = new_id_ff;
               rsp_in.result_tag  = item_ff.client_tag;
            end
         end
         rtirt_pkg::EMIT_NOTICE: begin
            rsp_in.result_kind = rtirt_pkg::KIND_NOTICE;
            rsp_in.id_value    = best_new_ff;
            rsp_in.result_tag  = best_tag_ff;
         end
         rtirt_pkg::EMIT_SENT: begin
            rsp_in.result_kind = rtirt_pkg::KIND_SENT;
            rsp_in.id_value    = new_id_ff;
            rsp_in.result_tag  = item_ff.client_tag;
            rsp_in.last_result = 1'b1;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (cmd.emit != rtirt_pkg::EMIT_NONE);
      end
      rsp_ff <= rsp_in;
   end

   `RTIRT_ASSERT_NXT(a_notice_then_sent, clock, reset, rsp_strobe_ff && !rsp_ff.last_result, rsp_strobe_ff && rsp_ff.last_result, "expiry notice not followed by final item")
   `RTIRT_ASSERT_IMP(a_notice_not_last, clock, reset, rsp_strobe_ff && (rsp_ff.result_kind == rtirt_pkg::KIND_NOTICE), !rsp_ff.last_result, "expiry notice marked last")
   `RTIRT_ASSERT_NXT(a_commit_counts, clock, reset, cmd.commit, ins_ctr_ff == $past(ins_ctr_ff) + 32'd1, "insert counter did not advance on writeback")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the transaction id remap table core.
// Depends on rtirt_pkg and rpc_transaction_id_remap_table_core; predicts each result in-line.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int N = rtirt_pkg::TABLE_ENTRIES;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   rtirt_pkg::req_item_type req_data = '0;
   logic                    rsp_strobe;
   rtirt_pkg::rsp_item_type rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [7:0]              csr_index = '0;
   logic [7:0]              csr_wdata = '0;

   rpc_transaction_id_remap_table_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted table state
   logic [7:0]   lifetime;
   logic         shutdown;
   logic         valid_q [N];
   logic [31:0]  new_id_q [N];
   logic [31:0]  old_id_q [N];
   logic [31:0]  expiry_q [N];
   logic [15:0]  tag_q [N];
   logic [31:0]  stamp_q [N];
   logic [27:0]  id_ctr;
   logic [31:0]  ins_ctr;

   rtirt_pkg::rsp_item_type pending_results [$];
   int           failures = 0;
   int           items_sent = 0;
   int           results_seen = 0;
   int           notices_seen = 0;
   int           fulls_seen = 0;
   int           matches_seen = 0;
   int           send_idle_pct = 0;
   longint       cycles = 0;

   // Recent handles used to build well-formed replies and qualified duplicates
   logic [31:0]  issued_ids [$];

   function automatic int find_recent(input logic by_id, input logic [31:0] id,
                                      input logic [31:0] now);
      int best;
      logic [31:0] best_age, age;
      best = -1;
      best_age = '0;
      for (int s = 0; s < N; s++) begin
         if (valid_q[s] && (by_id ? new_id_q[s] == id : expiry_q[s] <= now)) begin
            age = ins_ctr - stamp_q[s];
            if (best < 0 || age < best_age) begin
               best = s;
               best_age = age;
            end
         end
      end
      return best;
   endfunction

   function automatic rtirt_pkg::rsp_item_type make_result(
         input rtirt_pkg::result_kind_type kind, input logic [31:0] id,
         input logic [15:0] tag, input logic last);
      rtirt_pkg::rsp_item_type r;
      r.result_kind = kind;
      r.id_value = id;
      r.result_tag = tag;
      r.last_result = last;
      return r;
   endfunction

   task automatic predict_table(input rtirt_pkg::req_item_type it);
      int s;
      logic [31:0] nid;
      logic [32:0] sum;
      logic [15:0] tag;
      tag = it.client_tag & rtirt_pkg::TAG_MASK;
      if (it.req_type) begin
         s = shutdown ? -1 : find_recent(1'b1, it.reply_id, '0);
         if (s < 0) begin
            pending_results.push_back(make_result(rtirt_pkg::KIND_UNMATCHED, it.reply_id,
                                                  '0, 1'b1));
         end else begin
            valid_q[s] = 1'b0;
            pending_results.push_back(make_result(rtirt_pkg::KIND_MATCHED, old_id_q[s],
                                                  tag_q[s], 1'b1));
         end
         return;
      end
      if (shutdown) begin
         pending_results.push_back(make_result(rtirt_pkg::KIND_REJECTED, '0, tag, 1'b1));
         return;
      end
      if (it.type_id >> rtirt_pkg::TYPE_BITS != 0) begin
         nid = it.type_id;
         s = find_recent(1'b1, nid, '0);
         if (s >= 0) valid_q[s] = 1'b0;
      end else begin
         nid = {id_ctr, 4'b0} | it.type_id;
         id_ctr = id_ctr + 1'b1;
      end
      s = find_recent(1'b0, '0, it.now_seconds);
      if (s >= 0) begin
         pending_results.push_back(make_result(rtirt_pkg::KIND_NOTICE, new_id_q[s],
                                               tag_q[s], 1'b0));
      end else begin
         for (int f = N - 1; f >= 0; f--)
            if (!valid_q[f]) s = f;
         if (s < 0) begin
            pending_results.push_back(make_result(rtirt_pkg::KIND_FULL, nid, tag, 1'b1));
            return;
         end
      end
      sum = {1'b0, it.now_seconds} + {25'd0, lifetime};
      valid_q[s] = 1'b1;
      new_id_q[s] = nid;
      old_id_q[s] = it.original_id;
      expiry_q[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      tag_q[s] = tag;
      stamp_q[s] = ins_ctr;
      ins_ctr = ins_ctr + 1'b1;
      pending_results.push_back(make_result(rtirt_pkg::KIND_SENT, nid, tag, 1'b1));
      issued_ids.push_back(nid);
      if (issued_ids.size() > 40) void'(issued_ids.pop_front());
   endtask

   // Result checker: the block cannot be stalled, so sample every strobe
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result kind=%0d id=%h", rsp_data.result_kind, rsp_data.id_value);
            failures++;
         end else begin
            automatic rtirt_pkg::rsp_item_type exp_r = pending_results.pop_front();
            if (rsp_data.result_kind != exp_r.result_kind) begin
               $error("result_kind: expected %0d, actual %0d", exp_r.result_kind,
                      rsp_data.result_kind);
               failures++;
            end
            if (rsp_data.id_value != exp_r.id_value) begin
               $error("id_value: expected %h, actual %h", exp_r.id_value, rsp_data.id_value);
               failures++;
            end
            if (rsp_data.result_tag != exp_r.result_tag) begin
               $error("result_tag: expected %h, actual %h", exp_r.result_tag,
                      rsp_data.result_tag);
               failures++;
            end
            if (rsp_data.last_result != exp_r.last_result) begin
               $error("last_result: expected %0d, actual %0d", exp_r.last_result,
                      rsp_data.last_result);
               failures++;
            end
            case (exp_r.result_kind)
               rtirt_pkg::KIND_NOTICE:  notices_seen++;
               rtirt_pkg::KIND_FULL:    fulls_seen++;
               rtirt_pkg::KIND_MATCHED: matches_seen++;
               default: ;
            endcase
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_item(input rtirt_pkg::req_item_type it);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_data <= it;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      predict_table(it);
      items_sent++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == rtirt_pkg::CSR_LIFETIME) lifetime = value;
      else if (index == rtirt_pkg::CSR_SHUTDOWN) shutdown = value[0];
      @(posedge clock);
   endtask

   // Let the block finish all outstanding work before touching registers
   task automatic drain;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2 * N + 12) @(posedge clock);
   endtask

   function automatic rtirt_pkg::req_item_type forward_item(input logic [31:0] type_id,
                                                            input logic [31:0] now);
      rtirt_pkg::req_item_type it;
      it.req_type = 1'b0;
      it.type_id = type_id;
      it.original_id = $urandom;
      it.reply_id = $urandom;
      it.client_tag = 16'($urandom);
      it.now_seconds = now;
      return it;
   endfunction

   function automatic rtirt_pkg::req_item_type reply_item(input logic [31:0] rid);
      rtirt_pkg::req_item_type it;
      it = forward_item($urandom, $urandom);
      it.req_type = 1'b1;
      it.reply_id = rid;
      return it;
   endfunction

   task automatic test_directed;
      rtirt_pkg::req_item_type it;
      // fill the table with long-lived entries, then overflow it
      for (int k = 0; k < N; k++) send_item(forward_item(32'(k % 16), 32'd100));
      it = forward_item(32'h0000_000F, 32'd100);
      it.client_tag = 16'hFFFF;
      send_item(it);
      // reply to the newest and to an unknown id
      send_item(reply_item(issued_ids[$]));
      send_item(reply_item(32'hFFFF_FFFF));
      // first issued id resent as an unqualified type id, then expiry eviction at the edge
      send_item(forward_item(issued_ids[0], 32'd143));
      send_item(forward_item(32'hFFFF_FFF0, 32'hFFFF_FFFF));
      send_item(forward_item(32'd0, 32'd0));
      drain();
      write_reg(rtirt_pkg::CSR_LIFETIME, 8'd255);
      send_item(forward_item(32'h0000_0003, 32'hFFFF_FF80));
      drain();
      write_reg(rtirt_pkg::CSR_SHUTDOWN, 8'd1);
      send_item(forward_item(32'd1, 32'd5));
      send_item(reply_item(issued_ids[$]));
      drain();
      write_reg(rtirt_pkg::CSR_SHUTDOWN, 8'd0);
      write_reg(8'd7, 8'hAA);
   endtask

   task automatic test_random(input int count, input logic [7:0] life,
                              input int idle_pct);
      logic [31:0] now;
      logic [31:0] tid;
      int pick;
      drain();
      write_reg(rtirt_pkg::CSR_LIFETIME, life);
      send_idle_pct = idle_pct;
      now = $urandom_range(1000);
      for (int n = 0; n < count; n++) begin
         now = now + $urandom_range(3);
         pick = $urandom_range(99);
         if (pick < 45) begin
            tid = $urandom_range(15);
            send_item(forward_item(tid, now));
         end else if (pick < 80 && issued_ids.size() != 0) begin
            send_item(reply_item(issued_ids[$urandom_range(issued_ids.size() - 1)]));
         end else if (pick < 88 && issued_ids.size() != 0) begin
            send_item(forward_item(issued_ids[$urandom_range(issued_ids.size() - 1)], now));
         end else if (pick < 94) begin
            send_item(forward_item($urandom, $urandom));
         end else begin
            send_item(reply_item($urandom));
         end
      end
   endtask

   initial begin
      lifetime = rtirt_pkg::LIFETIME_RESET;
      shutdown = 1'b0;
      id_ctr = '0;
      ins_ctr = '0;
      for (int s = 0; s < N; s++) begin
         valid_q[s] = 1'b0;
         new_id_q[s] = '0;
         old_id_q[s] = '0;
         expiry_q[s] = '0;
         tag_q[s] = '0;
         stamp_q[s] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(480, 8'd1, 15);
      test_random(480, 8'd20, 82);
      test_random(490, 8'd0, 0);
      drain();
      $display("Sent %0d items, checked %0d results", items_sent, results_seen);
      $display("Expiry notices %0d, table full %0d, reply matches %0d", notices_seen,
               fulls_seen, matches_seen);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
